@@ hdl/fcw_pkg.sv @@
// fcw_pkg: shared constants, types and functions of the flow color wheel block
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package fcw_pkg;

  // payload widths
  localparam int FLOW_W = 16;
  localparam int CHAN_W = 8;
  localparam int MAXM_W = 16;

  // default wheel position fraction bits
  localparam int ANGLE_FRAC_BITS_DEF = 8;

  // reset value of the maximum motion register
  localparam logic [MAXM_W-1:0] MAXM_RST = 16'd320;

  // color wheel segment lengths
  localparam int RY = 15;
  localparam int YG = 6;
  localparam int GC = 4;
  localparam int CB = 11;
  localparam int BM = 13;
  localparam int MR = 6;
  localparam int NCOLS = RY + YG + GC + CB + BM + MR;

  // arithmetic sizes
  localparam int CORDIC_STEPS = 28;
  localparam int CR_W = 36;
  localparam int SQ_REM_W = 36;
  localparam int DV_REM_W = 34;
  localparam int DV_Q_W = 18;
  localparam int COL_W = 17;

  // half a turn on the 2^32 angle scale
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  // ceil(2^39 / 255), exact divide by 255 for 24 bit numerators
  localparam logic [31:0] RECIP_255 = 32'h8080_8081;
  localparam int RECIP_SHIFT = 39;
  localparam logic [COL_W-1:0] COL_ONE = 17'd65536;

  typedef logic [2:0][CHAN_W-1:0] rgb_t;
  typedef logic [2:0][COL_W-1:0] col3_t;

  typedef struct packed {
    logic signed [CR_W-1:0] x;
    logic signed [CR_W-1:0] y;
    logic [31:0]            ang;
  } cordic_st_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [31:0]         root;
    logic [31:0]         rad;
  } sqrt_st_t;

  typedef struct packed {
    logic [DV_REM_W-1:0] rem;
    logic [DV_Q_W-1:0]   q;
  } div_st_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] a;
    unique case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      24: a = 32'd41;
      25: a = 32'd20;
      26: a = 32'd10;
      27: a = 32'd5;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // one vectoring rotation toward y = 0
  function automatic cordic_st_t cordic_step(input cordic_st_t s, input int i);
    cordic_st_t o;
    logic signed [CR_W-1:0] xs;
    logic signed [CR_W-1:0] ys;
    xs = s.x >>> i;
    ys = s.y >>> i;
    if (!s.y[CR_W-1] && (s.y != '0)) begin
      o.x = s.x + ys;
      o.y = s.y - xs;
      o.ang = s.ang + atan_turn(i);
    end else begin
      o.x = s.x - ys;
      o.y = s.y + xs;
      o.ang = s.ang - atan_turn(i);
    end
    return o;
  endfunction

  // one digit of the square root of rad * 2^32, two radicand bits per digit
  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s, input int n);
    sqrt_st_t o;
    logic [1:0] bits;
    logic [SQ_REM_W-1:0] r;
    logic [SQ_REM_W-1:0] t;
    bits = (n < 16) ? 2'(s.rad >> (30 - 2 * n)) : 2'b00;
    r = {s.rem[SQ_REM_W-3:0], bits};
    t = {2'b00, s.root, 2'b01};
    o.rad = s.rad;
    if (r >= t) begin
      o.rem = r - t;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem = r;
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  // one quotient bit of a restoring divide
  function automatic div_st_t div_step(input div_st_t s, input logic [MAXM_W-1:0] d,
                                       input int i);
    div_st_t o;
    logic [DV_REM_W-1:0] t;
    t = DV_REM_W'(d) << i;
    if (s.rem >= t) begin
      o.rem = s.rem - t;
      o.q = {s.q[DV_Q_W-2:0], 1'b1};
    end else begin
      o.rem = s.rem;
      o.q = {s.q[DV_Q_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // color wheel entry for a constant index; 0 red, 1 green, 2 blue
  function automatic rgb_t wheel_entry(input int k);
    rgb_t c;
    int i;
    int r;
    int g;
    int b;
    i = k;
    if (i < RY) begin
      r = 255; g = 255 * i / RY; b = 0;
    end else if (i < RY + YG) begin
      r = 255 - 255 * (i - RY) / YG; g = 255; b = 0;
    end else if (i < RY + YG + GC) begin
      r = 0; g = 255; b = 255 * (i - RY - YG) / GC;
    end else if (i < RY + YG + GC + CB) begin
      r = 0; g = 255 - 255 * (i - RY - YG - GC) / CB; b = 255;
    end else if (i < RY + YG + GC + CB + BM) begin
      r = 255 * (i - RY - YG - GC - CB) / BM; g = 0; b = 255;
    end else begin
      i = i - (RY + YG + GC + CB + BM);
      if (i >= MR) begin
        i = MR - 1;
      end
      r = 255; g = 0; b = 255 - 255 * i / MR;
    end
    c[0] = 8'(r);
    c[1] = 8'(g);
    c[2] = 8'(b);
    return c;
  endfunction

  // color wheel lookup, a table of constant entries
  function automatic rgb_t wheel_rgb(input logic [5:0] k);
    rgb_t c;
    c = '0;
    for (int j = 0; j < NCOLS; j++) begin
      if (k == 6'(j)) begin
        c = wheel_entry(j);
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/fcw_flow_if.sv @@
// fcw_flow_if: input channel carrying one flow vector per transaction
// depends on fcw_pkg for the field widths
`default_nettype none

interface fcw_flow_if import fcw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [FLOW_W-1:0] flow_x;
  logic signed [FLOW_W-1:0] flow_y;
  logic                     flow_valid;

  modport source (output valid, output flow_x, output flow_y, output flow_valid,
                  input ready);
  modport sink (input valid, input flow_x, input flow_y, input flow_valid,
                output ready);
endinterface

`default_nettype wire

@@ hdl/fcw_color_if.sv @@
// fcw_color_if: result channel carrying one rgb pixel per transaction
// depends on fcw_pkg for the field widths
`default_nettype none

interface fcw_color_if import fcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

@@ hdl/fcw_cfg_if.sv @@
// fcw_cfg_if: write channel for the maximum motion register
// depends on fcw_pkg for the register width
`default_nettype none

interface fcw_cfg_if import fcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MAXM_W-1:0] max_motion;

  modport source (output valid, output max_motion, input ready);
  modport sink (input valid, input max_motion, output ready);
endinterface

`default_nettype wire

@@ hdl/flow_to_color_wheel_top.sv @@
// flow_to_color_wheel_top: pipelined optical flow to rgb color wheel coder
// depends on fcw_pkg and the fcw_flow_if, fcw_color_if and fcw_cfg_if interfaces
`default_nettype none

// Takes one flow vector per clock while out_ch is not stalled and presents its color on
// out_ch after 30 register stages, one pixel per clock sustained. The whole
// pipeline advances together and freezes while a finished pixel waits on
// out_ch.ready; bubbles stay in place. Latency is set by the magnitude path:
// squares, a 32 digit square root at two digits per stage and an 18 bit restoring
// divide at two bits per stage; the 28 step angle CORDIC (two steps per stage) runs
// beside it. The max_motion register is taken at any time (cfg_ch.ready is always
// high) and must only change while no pixel is in flight.
module flow_to_color_wheel_top import fcw_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  fcw_flow_if.sink    in_ch,
  fcw_color_if.source out_ch,
  fcw_cfg_if.sink     cfg_ch
);

  localparam int A      = ANGLE_FRAC_BITS;
  localparam int POS_W  = 6 + A;
  localparam int NUM_W  = 8 + A;
  localparam logic [POS_W-1:0] WSPAN = POS_W'((NCOLS - 1) << A);
  localparam logic [A:0] FONE = (A + 1)'(1) << A;
  localparam logic [5:0] KLAST = 6'(NCOLS - 1);

  // stage map
  localparam int RT_STG  = 16;
  localparam int CR_STG  = 14;
  localparam int DV_STG  = 9;
  localparam int S_POS   = 16;
  localparam int S_LUT   = 17;
  localparam int S_RT    = 18;
  localparam int S_COL   = 19;
  localparam int S_DV    = 27;
  localparam int S_MIX   = 28;
  localparam int NSTG    = 30;
  localparam int CD_LEN  = S_DV - S_COL + 1;

  logic adv;
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] fv_r;
  logic [S_DV:3]   rng_r;
  logic [S_POS-1:1] zy_r;
  logic [S_POS-1:1] xn_r;

  logic signed [FLOW_W-1:0] fx_r;
  logic signed [FLOW_W-1:0] fy_r;

  logic [MAXM_W-1:0]   mm_r;
  logic [2*MAXM_W-1:0] mm_sq_r;
  logic [MAXM_W-1:0]   mm_nxt;

  logic [30:0] sqx_r;
  logic [30:0] sqy_r;
  logic [31:0] m2_r;

  sqrt_st_t   rt_r   [RT_STG];
  sqrt_st_t   rt_nxt [RT_STG];
  div_st_t    dv_r   [DV_STG];
  div_st_t    dv_nxt [DV_STG];
  cordic_st_t ci_r;
  cordic_st_t ci_nxt;
  cordic_st_t cr_r   [CR_STG];
  cordic_st_t cr_nxt [CR_STG];

  logic [POS_W-1:0]   pos_r;
  logic [POS_W-1:0]   pos_nxt;
  logic [31:0]        turn;
  logic [31+POS_W:0]  pos_prod;
  logic [5:0]         k0;
  logic [5:0]         k1;
  logic [A-1:0]       f_r;
  rgb_t               c0_r;
  rgb_t               c1_r;
  logic [A:0]         fc;
  logic [2:0][NUM_W-1:0] num_r;
  logic [2:0][NUM_W-1:0] num_nxt;
  col3_t              col_nxt;
  col3_t              cd_r [CD_LEN];
  col3_t              mix_r;
  col3_t              mix_nxt;
  rgb_t               rgb_r;
  rgb_t               rgb_nxt;

  // the whole pipeline moves unless a finished pixel is held
  assign adv = !vld_r[NSTG-1] || out_ch.ready;
  assign in_ch.ready = adv;
  assign cfg_ch.ready = 1'b1;

  // max motion register, zero treated as one
  assign mm_nxt = (cfg_ch.max_motion == '0) ? MAXM_W'(1) : cfg_ch.max_motion;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_r <= MAXM_RST;
      mm_sq_r <= (2*MAXM_W)'(MAXM_RST) * (2*MAXM_W)'(MAXM_RST);
    end else if (cfg_ch.valid) begin
      mm_r <= mm_nxt;
      mm_sq_r <= (2*MAXM_W)'(mm_nxt) * (2*MAXM_W)'(mm_nxt);
    end
  end

  // valid bits and per item flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fv_r <= {fv_r[NSTG-2:0], in_ch.flow_valid};
      rng_r <= {rng_r[S_DV-1:3], (m2_r <= mm_sq_r)};
      zy_r <= {zy_r[S_POS-2:1], (fy_r == '0)};
      xn_r <= {xn_r[S_POS-2:1], fx_r[FLOW_W-1]};
      fx_r <= in_ch.flow_x;
      fy_r <= in_ch.flow_y;
    end
  end

  // magnitude: squares, sum
  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r <= 31'(32'(fx_r * fx_r));
      sqy_r <= 31'(32'(fy_r * fy_r));
      m2_r <= 32'(sqx_r) + 32'(sqy_r);
    end
  end

  // square root of m2 * 2^32, two digits per stage
  always_comb begin
    sqrt_st_t st;
    for (int j = 0; j < RT_STG; j++) begin
      if (j == 0) begin
        st.rem = '0;
        st.root = '0;
        st.rad = m2_r;
      end else begin
        st = rt_r[j-1];
      end
      st = sqrt_step(st, 2 * j);
      st = sqrt_step(st, 2 * j + 1);
      rt_nxt[j] = st;
    end
  end

  // quotient sqrt / max_motion, two bits per stage
  always_comb begin
    div_st_t ds;
    for (int j = 0; j < DV_STG; j++) begin
      if (j == 0) begin
        ds.rem = DV_REM_W'(rt_r[RT_STG-1].root);
        ds.q = '0;
      end else begin
        ds = dv_r[j-1];
      end
      ds = div_step(ds, mm_r, DV_Q_W - 1 - 2 * j);
      ds = div_step(ds, mm_r, DV_Q_W - 2 - 2 * j);
      dv_nxt[j] = ds;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rt_r <= rt_nxt;
      dv_r <= dv_nxt;
    end
  end

  // angle: fold left half plane, then two rotations per stage
  always_comb begin
    logic signed [CR_W-1:0] xe;
    logic signed [CR_W-1:0] ye;
    xe = CR_W'(fx_r) <<< 16;
    ye = CR_W'(fy_r) <<< 16;
    if (fx_r[FLOW_W-1]) begin
      ci_nxt.x = -xe;
      ci_nxt.y = -ye;
      ci_nxt.ang = HALF_TURN;
    end else begin
      ci_nxt.x = xe;
      ci_nxt.y = ye;
      ci_nxt.ang = '0;
    end
  end

  always_comb begin
    cordic_st_t cs;
    for (int j = 0; j < CR_STG; j++) begin
      cs = (j == 0) ? ci_r : cr_r[j-1];
      cs = cordic_step(cs, 2 * j);
      cs = cordic_step(cs, 2 * j + 1);
      cr_nxt[j] = cs;
    end
  end

  // wheel position, exact angle on the x axis
  assign turn = zy_r[S_POS-1] ? (xn_r[S_POS-1] ? HALF_TURN : 32'd0) : cr_r[CR_STG-1].ang;
  assign pos_prod = (32 + POS_W)'(turn) * (32 + POS_W)'(WSPAN);
  assign pos_nxt = pos_prod[31+POS_W:32];

  // neighboring wheel entries
  always_comb begin
    k0 = pos_r[POS_W-1:A];
    if (k0 > KLAST) begin
      k0 = KLAST;
    end
    k1 = (k0 == KLAST) ? 6'd0 : k0 + 6'd1;
  end

  // blend numerators
  assign fc = FONE - (A + 1)'(f_r);
  always_comb begin
    logic [NUM_W:0] p0;
    logic [NUM_W:0] p1;
    for (int ch = 0; ch < 3; ch++) begin
      p0 = (NUM_W + 1)'(fc) * (NUM_W + 1)'(c0_r[ch]);
      p1 = (NUM_W + 1)'(f_r) * (NUM_W + 1)'(c1_r[ch]);
      num_nxt[ch] = NUM_W'(p0 + p1);
    end
  end

  // divide by 255 * 2^A through the reciprocal
  always_comb begin
    logic [23:0] nn;
    logic [55:0] pr;
    logic [COL_W-1:0] cq;
    for (int ch = 0; ch < 3; ch++) begin
      nn = 24'(num_r[ch]) << (16 - A);
      pr = 56'(nn) * 56'(RECIP_255);
      cq = COL_W'(pr >> RECIP_SHIFT);
      col_nxt[ch] = (cq > COL_ONE) ? COL_ONE : cq;
    end
  end

  // saturation from magnitude, or dimmed when out of range
  always_comb begin
    logic [COL_W-1:0] s16;
    logic [COL_W-1:0] inv;
    logic [2*COL_W-1:0] sp;
    logic [COL_W+1:0] c3;
    s16 = COL_W'(dv_r[DV_STG-1].q);
    for (int ch = 0; ch < 3; ch++) begin
      inv = COL_ONE - cd_r[CD_LEN-1][ch];
      sp = (2*COL_W)'(s16) * (2*COL_W)'(inv);
      c3 = (COL_W + 2)'(cd_r[CD_LEN-1][ch]) * (COL_W + 2)'(3);
      if (rng_r[S_DV]) begin
        mix_nxt[ch] = COL_ONE - COL_W'(sp >> 16);
      end else begin
        mix_nxt[ch] = COL_W'(c3 >> 2);
      end
    end
  end

  // scale to 8 bit channels, black for unusable vectors
  always_comb begin
    logic [COL_W+7:0] v;
    for (int ch = 0; ch < 3; ch++) begin
      v = ((COL_W + 8)'(mix_r[ch]) << 8) - (COL_W + 8)'(mix_r[ch]);
      rgb_nxt[ch] = fv_r[S_MIX] ? v[23:16] : '0;
    end
  end

  // angle and color datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      ci_r <= ci_nxt;
      cr_r <= cr_nxt;
      pos_r <= pos_nxt;
      f_r <= pos_r[A-1:0];
      c0_r <= wheel_rgb(k0);
      c1_r <= wheel_rgb(k1);
      num_r <= num_nxt;
      cd_r[0] <= col_nxt;
      for (int i = 1; i < CD_LEN; i++) begin
        cd_r[i] <= cd_r[i-1];
      end
      mix_r <= mix_nxt;
      rgb_r <= rgb_nxt;
    end
  end

  assign out_ch.valid = vld_r[NSTG-1];
  assign out_ch.red   = rgb_r[0];
  assign out_ch.green = rgb_r[1];
  assign out_ch.blue  = rgb_r[2];

`ifndef ASSERT_OFF
  // the square root is exact for the radicand carried with it
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[S_RT] |->
      (66'(rt_r[RT_STG-1].root) * 66'(rt_r[RT_STG-1].root) <= {2'b00, rt_r[RT_STG-1].rad, 32'd0})
      && ((66'(rt_r[RT_STG-1].root) + 66'd1) * (66'(rt_r[RT_STG-1].root) + 66'd1)
          > {2'b00, rt_r[RT_STG-1].rad, 32'd0}))
    else $error("square root digit recurrence off");

  // an in-range magnitude never saturates above one
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[S_DV] && rng_r[S_DV] |-> dv_r[DV_STG-1].q <= DV_Q_W'(COL_ONE))
    else $error("saturation quotient exceeds one");

  // the wheel index stays on the wheel
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[S_LUT] |-> pos_r[POS_W-1:A] < KLAST)
    else $error("wheel position beyond last entry");

  // an unusable vector comes out black
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTG-1] && !fv_r[NSTG-1] |-> rgb_r == '0)
    else $error("invalid vector not black");

  // a held pixel keeps the pipeline frozen
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTG-1] && !out_ch.ready |=> $stable(vld_r))
    else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire

@@ test/tb.sv @@
// tb: self-checking testbench for flow_to_color_wheel_top
// predicts each pixel color with the flow_color function and checks it against out_ch
// depends on fcw_pkg, the three channel interfaces and the top level
`timescale 1ns / 1ps

module tb import fcw_pkg::*; ();

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  localparam int LATENCY = 30;

  logic clk;
  logic rst_n;
  logic [15:0] cur_max_motion;
  bit no_gaps;
  int errors;
  int sent;
  int checked;
  pixel_t pixel_q[$];

  fcw_flow_if  in_ch ();
  fcw_color_if out_ch ();
  fcw_cfg_if   cfg_ch ();

  flow_to_color_wheel_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #(20 * 200000);
    $display("flow_to_color_wheel_top: mismatch");
    $finish;
  end

  // atan(2^-i) in 2^-32 turn
  function automatic longint unsigned atan_step_angle(input int i);
    longint unsigned t[28] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};
    return t[i];
  endfunction

  // wheel entry channel value
  function automatic int wheel_value(input int k, input int ch);
    int c[3];
    int i;
    i = k;
    if (i < 15) begin
      c = '{255, 255 * i / 15, 0};
    end else if (i < 21) begin
      i -= 15; c = '{255 - 255 * i / 6, 255, 0};
    end else if (i < 25) begin
      i -= 21; c = '{0, 255, 255 * i / 4};
    end else if (i < 36) begin
      i -= 25; c = '{0, 255 - 255 * i / 11, 255};
    end else if (i < 49) begin
      i -= 36; c = '{255 * i / 13, 0, 255};
    end else begin
      i -= 49;
      if (i >= 6) i = 5;
      c = '{255, 0, 255 - 255 * i / 6};
    end
    return c[ch];
  endfunction

  // direction of the flow vector as a 32 bit turn
  function automatic logic [31:0] flow_turn(input longint fx, input longint fy);
    longint x;
    longint y;
    longint xs;
    longint ys;
    logic [31:0] ang;
    x = fx * 65536;
    y = fy * 65536;
    ang = 0;
    if (fy == 0) return (fx < 0) ? 32'h8000_0000 : 32'h0;
    if (x < 0) begin
      x = -x; y = -y; ang = 32'h8000_0000;
    end
    for (int i = 0; i < 28; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; ang += 32'(atan_step_angle(i));
      end else begin
        x -= ys; y += xs; ang -= 32'(atan_step_angle(i));
      end
    end
    return ang;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic pixel_t flow_color(input logic signed [15:0] fx,
                                        input logic signed [15:0] fy, input logic fv);
    pixel_t p;
    longint x;
    longint y;
    longint unsigned m2;
    longint unsigned mm;
    longint unsigned s16;
    longint unsigned pos;
    longint unsigned num;
    longint unsigned col;
    int k0;
    int k1;
    int f;
    bit in_range;
    int ch_val[3];
    p = '0;
    if (!fv) return p;
    x = fx;
    y = fy;
    mm = (cur_max_motion == 0) ? 1 : cur_max_motion;
    m2 = longint'(x * x) + longint'(y * y);
    in_range = m2 <= mm * mm;
    s16 = in_range ? int_sqrt(m2 << 32) / mm : 0;
    pos = (longint'(flow_turn(x, y)) * (54 << 8)) >> 32;
    k0 = int'(pos >> 8);
    if (k0 > 54) k0 = 54;
    k1 = (k0 + 1) % 55;
    f = int'(pos & 255);
    for (int ch = 0; ch < 3; ch++) begin
      num = longint'(256 - f) * wheel_value(k0, ch) + longint'(f) * wheel_value(k1, ch);
      col = (num << 16) / (255 << 8);
      if (col > 65536) col = 65536;
      if (in_range) col = 65536 - ((s16 * (65536 - col)) >> 16);
      else col = (col * 3) >> 2;
      ch_val[ch] = int'(((255 * col) >> 16) & 255);
    end
    p.red = 8'(ch_val[0]);
    p.green = 8'(ch_val[1]);
    p.blue = 8'(ch_val[2]);
    return p;
  endfunction

  // random idle burst on the sender side
  task automatic sender_gap();
    if (!no_gaps && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // send one flow vector and queue its color; valid stays up for the next one
  task automatic send_flow(input logic signed [15:0] fx, input logic signed [15:0] fy,
                           input logic fv);
    sender_gap();
    in_ch.valid <= 1'b1;
    in_ch.flow_x <= fx;
    in_ch.flow_y <= fy;
    in_ch.flow_valid <= fv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pixel_q.push_back(flow_color(fx, fy, fv));
    sent++;
  endtask

  // wait for every pixel, then write the register
  task automatic write_max_motion(input logic [15:0] v);
    in_ch.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.max_motion <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cur_max_motion = v;
  endtask

  // result checker
  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel r=%0d g=%0d b=%0d", out_ch.red, out_ch.green,
               out_ch.blue);
        errors++;
      end else begin
        e = pixel_q.pop_front();
        checked++;
        if (out_ch.red !== e.red) begin
          $error("red expected %0d actual %0d", e.red, out_ch.red); errors++;
        end
        if (out_ch.green !== e.green) begin
          $error("green expected %0d actual %0d", e.green, out_ch.green); errors++;
        end
        if (out_ch.blue !== e.blue) begin
          $error("blue expected %0d actual %0d", e.blue, out_ch.blue); errors++;
        end
      end
    end
  end

  // receiver stall bursts
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!no_gaps && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic test_directed();
    send_flow(16'sd0, 16'sd0, 1'b1);
    send_flow(16'sd100, 16'sd0, 1'b1);
    send_flow(-16'sd100, 16'sd0, 1'b1);
    send_flow(16'sd0, 16'sd100, 1'b1);
    send_flow(16'sd0, -16'sd100, 1'b1);
    send_flow(16'sd200, 16'sd200, 1'b1);
    send_flow(-16'sd200, -16'sd150, 1'b1);
    send_flow(16'sd320, 16'sd0, 1'b1);
    send_flow(16'sd321, 16'sd0, 1'b1);
    send_flow(16'sh7fff, 16'sh7fff, 1'b1);
    send_flow(-16'sd32768, -16'sd32768, 1'b1);
    send_flow(-16'sd32768, 16'sh7fff, 1'b1);
    send_flow(16'sh7fff, -16'sd32768, 1'b1);
    send_flow(-16'sd32768, 16'sd0, 1'b1);
    send_flow(-16'sd5, 16'sd1, 1'b1);
    send_flow(-16'sd5, -16'sd1, 1'b1);
    send_flow(16'sh7fff, 16'sh7fff, 1'b0);
    send_flow(-16'sd1, -16'sd1, 1'b0);
  endtask

  task automatic test_random(input int n);
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    int lim;
    for (int i = 0; i < n; i++) begin
      // most vectors near the saturation range, some full scale
      lim = ($urandom_range(0, 3) == 0) ? 32767 : 2 * int'(cur_max_motion) + 2;
      if (lim > 32767) lim = 32767;
      if ($urandom_range(0, 7) == 0) begin
        fx = 16'($urandom); fy = 16'($urandom);
      end else begin
        fx = 16'(int'($urandom_range(0, 2 * lim)) - lim);
        fy = 16'(int'($urandom_range(0, 2 * lim)) - lim);
      end
      if ($urandom_range(0, 15) == 0) fy = '0;
      send_flow(fx, fy, $urandom_range(0, 9) != 0);
    end
  endtask

  task automatic test_max_motion_sweep();
    logic [15:0] settings[6] = '{16'd1, 16'd65535, 16'd0, 16'd10, 16'd4000, 16'd320};
    foreach (settings[i]) begin
      write_max_motion(settings[i]);
      test_random(250);
    end
    write_max_motion(16'($urandom_range(1, 65535)));
    test_random(200);
  endtask

  initial begin
    int wait_cycles;
    errors = 0;
    sent = 0;
    checked = 0;
    no_gaps = 0;
    cur_max_motion = MAXM_RST;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.flow_x = '0;
    in_ch.flow_y = '0;
    in_ch.flow_valid = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.max_motion = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(80);
    test_max_motion_sweep();
    no_gaps = 1;
    test_random(150);
    in_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (pixel_q.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY) @(posedge clk);
    $display("covered %0d flow vectors, %0d pixels checked, max_motion sweep incl. 0/1/65535",
             sent, checked);
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("flow_to_color_wheel_top: match");
    end else begin
      $display("flow_to_color_wheel_top: mismatch");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hdl/fcw_pkg.sv
hdl/fcw_flow_if.sv
hdl/fcw_color_if.sv
hdl/fcw_cfg_if.sv
hdl/flow_to_color_wheel_top.sv
test/tb.sv
